// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEAP_BYTES   = 4096;
	localparam int HEADER_BYTES = 8;
	localparam int GRANULES     = HEAP_BYTES / 8;
	localparam int HDR_GRAN     = HEADER_BYTES / 8;

	// chunk index, chunk size in granules, header word
	localparam int IDX_W  = $clog2(GRANULES);
	localparam int SIZE_W = IDX_W + 1;
	localparam int HDR_W  = SIZE_W + 1;

	// granules needed by an allocate: header plus up to 4095 bytes rounded up
	localparam int NEED_W = 10;
	// common width for compares between sizes, indexes and pointer granules
	localparam int CW = (SIZE_W + 1 > NEED_W + 1) ? SIZE_W + 1 : NEED_W + 1;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_LEAK  = 2'd2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_MEM    = 3'd1,
		ST_OOB       = 3'd2,
		ST_DBL_FREE  = 3'd3,
		ST_INSIDE    = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_MERGE,
		S_FWR,
		S_WR2,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [HDR_W-1:0] data;
	} hdr_wr_t;

	// header word of the single free chunk after reset
	localparam logic [HDR_W-1:0] HDR_RESET = {SIZE_W'(GRANULES), 1'b0};

endpackage

// ===== rtl/ffha_req_if.sv =====
// ----------------------------------------------------------------------------
// ffha_req_if
// Request channel of the heap allocator: valid/ready plus request fields.
// ----------------------------------------------------------------------------
interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [11:0] request_bytes;
	logic        null_pointer;
	logic [12:0] payload_offset;

	modport source (
		output valid, req_type, request_bytes, null_pointer, payload_offset,
		input  ready
	);
	modport sink (
		input  valid, req_type, request_bytes, null_pointer, payload_offset,
		output ready
	);
endinterface

// ===== rtl/ffha_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ffha_rsp_if
// Response channel of the heap allocator: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [11:0] alloc_offset;
	logic [12:0] leaked_bytes;
	logic [9:0]  leaked_objects;

	modport source (
		output valid, status, alloc_offset, leaked_bytes, leaked_objects,
		input  ready
	);
	modport sink (
		input  valid, status, alloc_offset, leaked_bytes, leaked_objects,
		output ready
	);
endinterface

// ===== rtl/ffha_hdr_store.sv =====
// ----------------------------------------------------------------------------
// ffha_hdr_store
// Chunk header memory, one entry per granule, one write and one registered
// read per cycle. Entry 0 reads as the whole-heap free chunk until written.
// ----------------------------------------------------------------------------
module ffha_hdr_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ffha_pkg::IDX_W-1:0]    rd_addr,
	output logic [ffha_pkg::HDR_W-1:0]    rd_hdr,
	input  ffha_pkg::hdr_wr_t             wr
);

	logic [ffha_pkg::HDR_W-1:0] mem [ffha_pkg::GRANULES];
	logic [ffha_pkg::HDR_W-1:0] rd_data_q;
	logic                       rd_is0_q;
	logic                       hdr0_wr_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_is0_q  <= 1'b0;
			hdr0_wr_q <= 1'b0;
		end else begin
			rd_is0_q <= (rd_addr == '0);
			if (wr.en && wr.addr == '0) begin
				hdr0_wr_q <= 1'b1;
			end
		end
	end

	assign rd_hdr = (rd_is0_q && !hdr0_wr_q) ? ffha_pkg::HDR_RESET : rd_data_q;

endmodule

// ===== rtl/first_fit_heap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator over an implicit chunk list with free-time coalescing.
// ----------------------------------------------------------------------------
// One request is handled at a time. The sequencer walks the chunk headers in
// the header memory at one header per cycle, the next address coming from an
// index adder fed by the header just read. An allocate visits chunks until
// one fits, then writes the header of a split remainder, if any, and posts the
// result; a free walks the chunks up to the pointer, merges the following free
// chunks and makes up to two header writes; a leak report walks every chunk.
// Null frees, out-of-bounds pointers and unknown request types skip the walk
// and go straight to the result. The result sits in an output register until
// taken, and the next request is accepted once the result has been loaded
// into it.
module first_fit_heap_allocator_core (
	input  logic     clk,
	input  logic     arst_n,
	ffha_req_if.sink   req,
	ffha_rsp_if.source rsp
);

	localparam int IW = ffha_pkg::IDX_W;
	localparam int SW = ffha_pkg::SIZE_W;
	localparam int HW = ffha_pkg::HDR_W;
	localparam int NW = ffha_pkg::NEED_W;
	localparam int CW = ffha_pkg::CW;

	ffha_pkg::state_t  state_q, state_d;
	logic [1:0]        op_q;
	logic [NW-1:0]     need_q;
	logic [12:0]       ptr_q;
	logic [IW-1:0]     i_q;
	logic [IW-1:0]     j_q;
	logic [SW-1:0]     sz_q;
	logic [IW-1:0]     prev_q;
	logic [SW-1:0]     prev_sz_q;
	logic              prev_al_q;
	logic              have_prev_q;
	logic [IW-1:0]     w2_addr_q;
	logic [HW-1:0]     w2_hdr_q;
	ffha_pkg::status_t status_q;
	logic [11:0]       off_q;
	logic [SW-1:0]     lgran_q;
	logic [SW-1:0]     lobj_q;

	logic              rsp_valid_q;
	ffha_pkg::status_t rsp_status_q;
	logic [11:0]       rsp_off_q;
	logic [12:0]       rsp_bytes_q;
	logic [9:0]        rsp_objs_q;

	logic [IW-1:0]     rd_addr;
	logic [HW-1:0]     rd_hdr;
	ffha_pkg::hdr_wr_t wr;

	logic              accept;
	logic              load_rsp;
	logic [NW-1:0]     need_in;
	logic              ptr_oob;
	logic [SW-1:0]     hdr_sz;
	logic              hdr_al;
	logic              sz_zero;
	logic [SW-1:0]     nxt;
	logic              walk_end;
	logic              fit;
	logic              split;
	logic [SW-1:0]     split_addr;
	logic              split_ok;
	logic              ptr_match;
	logic              ptr_inside;
	logic [SW-1:0]     m_nxt;
	logic              m_stop;
	logic              prev_merge;

	ffha_hdr_store u_hdr_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_hdr  (rd_hdr),
		.wr      (wr)
	);

	assign accept   = req.valid && req.ready;
	assign load_rsp = (state_q == ffha_pkg::S_DONE) && (!rsp_valid_q || rsp.ready);
	assign need_in  = NW'(ffha_pkg::HDR_GRAN)
		+ NW'((13'(req.request_bytes) + 13'd7) >> 3);
	assign ptr_oob  = (32'(req.payload_offset) >= ffha_pkg::HEAP_BYTES);

	// evaluation of the header read for the current chunk
	always_comb begin
		hdr_sz     = rd_hdr[HW-1:1];
		hdr_al     = rd_hdr[0];
		sz_zero    = (hdr_sz == '0);
		nxt        = SW'(i_q) + hdr_sz;
		walk_end   = nxt[IW];
		fit        = !hdr_al && (CW'(need_q) <= CW'(hdr_sz));
		split      = CW'(need_q) < CW'(hdr_sz);
		split_addr = SW'(i_q) + SW'(need_q);
		split_ok   = split && !split_addr[IW];
		ptr_match  = (ptr_q[2:0] == 3'd0) && (CW'(ptr_q[12:3]) == CW'(i_q) + CW'(1));
		ptr_inside = (CW'(ptr_q[12:3]) >= CW'(i_q)) && (CW'(ptr_q[12:3]) < CW'(nxt));
		m_nxt      = SW'(j_q) + hdr_sz;
		m_stop     = sz_zero || hdr_al;
		prev_merge = have_prev_q && !prev_al_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffha_pkg::S_IDLE: begin
				if (accept) begin
					unique case (req.req_type) inside
						ffha_pkg::REQ_ALLOC, ffha_pkg::REQ_LEAK: state_d = ffha_pkg::S_WALK;
						ffha_pkg::REQ_FREE: begin
							if (req.null_pointer || ptr_oob) state_d = ffha_pkg::S_DONE;
							else state_d = ffha_pkg::S_WALK;
						end
						default: state_d = ffha_pkg::S_DONE;
					endcase
				end
			end
			ffha_pkg::S_WALK: begin
				case (op_q)
					ffha_pkg::REQ_ALLOC: begin
						if (sz_zero) state_d = ffha_pkg::S_DONE;
						else if (fit) state_d = split_ok ? ffha_pkg::S_WR2 : ffha_pkg::S_DONE;
						else if (walk_end) state_d = ffha_pkg::S_DONE;
					end
					ffha_pkg::REQ_FREE: begin
						if (sz_zero) state_d = ffha_pkg::S_DONE;
						else if (ptr_match) begin
							if (!hdr_al) state_d = ffha_pkg::S_DONE;
							else if (walk_end) state_d = ffha_pkg::S_FWR;
							else state_d = ffha_pkg::S_MERGE;
						end else if (ptr_inside || walk_end) state_d = ffha_pkg::S_DONE;
					end
					default: begin
						if (sz_zero || walk_end) state_d = ffha_pkg::S_DONE;
					end
				endcase
			end
			ffha_pkg::S_MERGE: begin
				if (m_stop || m_nxt[IW]) state_d = ffha_pkg::S_FWR;
			end
			ffha_pkg::S_FWR: state_d = prev_merge ? ffha_pkg::S_WR2 : ffha_pkg::S_DONE;
			ffha_pkg::S_WR2: state_d = ffha_pkg::S_DONE;
			ffha_pkg::S_DONE: begin
				if (load_rsp) state_d = ffha_pkg::S_IDLE;
			end
			default: state_d = ffha_pkg::S_IDLE;
		endcase
	end

	// memory port and handshake controls
	always_comb begin
		req.ready = (state_q == ffha_pkg::S_IDLE);
		rd_addr   = '0;
		wr        = '0;
		unique case (state_q)
			ffha_pkg::S_WALK: begin
				rd_addr = nxt[IW-1:0];
				if (op_q == ffha_pkg::REQ_ALLOC && !sz_zero && fit) begin
					wr.en   = 1'b1;
					wr.addr = i_q;
					wr.data = {SW'(need_q), 1'b1};
				end
			end
			ffha_pkg::S_MERGE: rd_addr = m_nxt[IW-1:0];
			ffha_pkg::S_FWR: begin
				wr.en   = 1'b1;
				wr.addr = i_q;
				wr.data = {sz_q, 1'b0};
			end
			ffha_pkg::S_WR2: begin
				wr.en   = 1'b1;
				wr.addr = w2_addr_q;
				wr.data = w2_hdr_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffha_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_rsp) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	// walk registers and results
	always_ff @(posedge clk) begin
		case (state_q)
			ffha_pkg::S_IDLE: begin
				if (accept) begin
					op_q        <= req.req_type;
					need_q      <= need_in;
					ptr_q       <= req.payload_offset;
					i_q         <= '0;
					have_prev_q <= 1'b0;
					off_q       <= '0;
					lgran_q     <= '0;
					lobj_q      <= '0;
					if (req.req_type == ffha_pkg::REQ_FREE && !req.null_pointer && ptr_oob)
						status_q <= ffha_pkg::ST_OOB;
					else
						status_q <= ffha_pkg::ST_OK;
				end
			end
			ffha_pkg::S_WALK: begin
				case (op_q)
					ffha_pkg::REQ_ALLOC: begin
						i_q <= nxt[IW-1:0];
						if (!sz_zero && fit) begin
							off_q     <= 12'((SW + 3)'({SW'(i_q) + SW'(1), 3'b000}));
							w2_addr_q <= split_addr[IW-1:0];
							w2_hdr_q  <= {hdr_sz - SW'(need_q), 1'b0};
						end else if (sz_zero || walk_end) begin
							status_q <= ffha_pkg::ST_NO_MEM;
						end
					end
					ffha_pkg::REQ_FREE: begin
						if (sz_zero) begin
							status_q <= ffha_pkg::ST_NOT_FOUND;
						end else if (ptr_match) begin
							// hold the matched chunk for merging
							sz_q <= hdr_sz;
							j_q  <= nxt[IW-1:0];
							if (!hdr_al) status_q <= ffha_pkg::ST_DBL_FREE;
						end else begin
							i_q         <= nxt[IW-1:0];
							prev_q      <= i_q;
							prev_sz_q   <= hdr_sz;
							prev_al_q   <= hdr_al;
							have_prev_q <= 1'b1;
							if (ptr_inside) begin
								status_q <= ffha_pkg::ST_INSIDE;
							end else if (walk_end) begin
								status_q <= ffha_pkg::ST_NOT_FOUND;
							end
						end
					end
					default: begin
						i_q <= nxt[IW-1:0];
						if (!sz_zero && hdr_al) begin
							lgran_q <= lgran_q + hdr_sz - SW'(1);
							lobj_q  <= lobj_q + SW'(1);
						end
					end
				endcase
			end
			ffha_pkg::S_MERGE: begin
				if (!m_stop) begin
					sz_q <= sz_q + hdr_sz;
					j_q  <= m_nxt[IW-1:0];
				end
			end
			ffha_pkg::S_FWR: begin
				w2_addr_q <= prev_q;
				w2_hdr_q  <= {prev_sz_q + sz_q, 1'b0};
			end
			ffha_pkg::S_DONE: begin
				if (load_rsp) begin
					rsp_status_q <= status_q;
					rsp_off_q    <= off_q;
					rsp_bytes_q  <= 13'((SW + 3)'({lgran_q, 3'b000}));
					rsp_objs_q   <= 10'(lobj_q);
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.alloc_offset   = rsp_off_q;
	assign rsp.leaked_bytes   = rsp_bytes_q;
	assign rsp.leaked_objects = rsp_objs_q;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit heap allocator core. A driver and a
// monitor sit on the request and response channels. Every accepted request
// runs through a shadow heap of chunk headers, and each response is checked
// field by field against that heap's answer. Directed corner requests come
// first. Random traffic follows: allocates, leak reports, frees of live
// chunks and bad pointers, over several sender and receiver stall profiles.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int RANDOM_ITEMS = 1500;
	localparam int DRAIN_CYCLES = 600;
	localparam int HOLD_CYCLES  = 800;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] nbytes;
		logic        is_null;
		logic [12:0] ptr;
	} heap_req_t;

	typedef struct packed {
		ffha_pkg::status_t status;
		logic [11:0]       offset;
		logic [12:0]       leak_bytes;
		logic [9:0]        leak_count;
	} heap_result_t;

	logic clk;
	logic arst_n;
	logic hold_off;

	ffha_req_if req_ch ();
	ffha_rsp_if rsp_ch ();

	first_fit_heap_allocator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the chunk headers: size in granules above the busy bit
	logic [ffha_pkg::HDR_W-1:0] heap_hdr [ffha_pkg::GRANULES];

	heap_req_t    pend_q [$];
	heap_result_t expected_q [$];
	heap_req_t    cur_req;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int n_errors       = 0;
	int n_sent         = 0;
	int n_checked      = 0;
	int n_leak_reports = 0;
	int peak_live      = 0;
	int status_cnt [6] = '{default: 0};

	// ------------------------------------------------------------------
	// shadow heap
	// ------------------------------------------------------------------
	function automatic int chunk_gran(int g);
		return int'(heap_hdr[g][ffha_pkg::HDR_W-1:1]);
	endfunction

	function automatic bit chunk_busy(int g);
		return heap_hdr[g][0];
	endfunction

	function automatic heap_result_t heap_alloc(int nbytes);
		heap_result_t res;
		int need;
		int i;
		int sz;
		res = '0;
		res.status = ffha_pkg::ST_NO_MEM;
		need = ffha_pkg::HDR_GRAN + ((nbytes + 7) >> 3);
		i = 0;
		while (i < ffha_pkg::GRANULES) begin
			sz = chunk_gran(i);
			if (sz == 0)
				break;
			if (!chunk_busy(i) && need <= sz) begin
				heap_hdr[i] = {ffha_pkg::SIZE_W'(need), 1'b1};
				if (need < sz && i + need < ffha_pkg::GRANULES)
					heap_hdr[i + need] = {ffha_pkg::SIZE_W'(sz - need), 1'b0};
				res.status = ffha_pkg::ST_OK;
				// a header-only chunk in the last granule wraps to offset zero
				res.offset = 12'(i * 8 + ffha_pkg::HEADER_BYTES);
				return res;
			end
			i += sz;
		end
		return res;
	endfunction

	function automatic ffha_pkg::status_t heap_free(int p);
		int i;
		int sz;
		int nsz;
		int start;
		int prev;
		bit have_prev;
		i = 0;
		prev = 0;
		have_prev = 1'b0;
		if (p >= ffha_pkg::HEAP_BYTES)
			return ffha_pkg::ST_OOB;
		while (i < ffha_pkg::GRANULES) begin
			sz = chunk_gran(i);
			start = i * 8;
			if (sz == 0)
				break;
			if (p == start + ffha_pkg::HEADER_BYTES) begin
				if (!chunk_busy(i))
					return ffha_pkg::ST_DBL_FREE;
				// absorb free neighbors that follow
				while (i + sz < ffha_pkg::GRANULES) begin
					nsz = chunk_gran(i + sz);
					if (nsz == 0 || chunk_busy(i + sz))
						break;
					sz += nsz;
				end
				heap_hdr[i] = {ffha_pkg::SIZE_W'(sz), 1'b0};
				if (have_prev && !chunk_busy(prev))
					heap_hdr[prev] = {ffha_pkg::SIZE_W'(chunk_gran(prev) + sz), 1'b0};
				return ffha_pkg::ST_OK;
			end
			if (p >= start && p < start + sz * 8)
				return ffha_pkg::ST_INSIDE;
			prev = i;
			have_prev = 1'b1;
			i += sz;
		end
		return ffha_pkg::ST_NOT_FOUND;
	endfunction

	function automatic heap_result_t heap_leaks();
		heap_result_t res;
		int i;
		int sz;
		int nbytes;
		int nobj;
		res = '0;
		res.status = ffha_pkg::ST_OK;
		i = 0;
		nbytes = 0;
		nobj = 0;
		while (i < ffha_pkg::GRANULES) begin
			sz = chunk_gran(i);
			if (sz == 0)
				break;
			if (chunk_busy(i)) begin
				nbytes += sz * 8 - ffha_pkg::HEADER_BYTES;
				nobj++;
			end
			i += sz;
		end
		res.leak_bytes = 13'(nbytes);
		res.leak_count = 10'(nobj);
		return res;
	endfunction

	function automatic heap_result_t heap_predict(heap_req_t r);
		heap_result_t res;
		res = '0;
		res.status = ffha_pkg::ST_OK;
		case (r.kind)
			ffha_pkg::REQ_ALLOC: begin
				res = heap_alloc(int'(r.nbytes));
			end
			ffha_pkg::REQ_FREE: begin
				if (!r.is_null)
					res.status = heap_free(int'(r.ptr));
			end
			ffha_pkg::REQ_LEAK: begin
				res = heap_leaks();
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// payload offset of a random chunk in the given busy state, -1 if none
	function automatic int pick_chunk(bit want_busy);
		int hits [$];
		int i;
		int sz;
		i = 0;
		while (i < ffha_pkg::GRANULES) begin
			sz = chunk_gran(i);
			if (sz == 0)
				break;
			if (chunk_busy(i) == want_busy)
				hits.push_back(i * 8 + ffha_pkg::HEADER_BYTES);
			i += sz;
		end
		if (hits.size() == 0)
			return -1;
		return hits[$urandom_range(hits.size() - 1)];
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic flag_mismatch(string what, int got, int want);
		$display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
		n_errors++;
	endtask

	// ------------------------------------------------------------------
	// clock, reset, time limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d transactions still expected", expected_q.size());
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// request driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid          <= 1'b0;
			req_ch.req_type       <= '0;
			req_ch.request_bytes  <= '0;
			req_ch.null_pointer   <= 1'b0;
			req_ch.payload_offset <= '0;
			foreach (heap_hdr[k])
				heap_hdr[k] = '0;
			heap_hdr[0] = ffha_pkg::HDR_RESET;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				heap_result_t res;
				res = heap_predict(cur_req);
				expected_q.push_back(res);
				status_cnt[int'(res.status)]++;
				if (cur_req.kind == ffha_pkg::REQ_LEAK) begin
					n_leak_reports++;
					if (int'(res.leak_count) > peak_live)
						peak_live = int'(res.leak_count);
				end
				n_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_req = pend_q.pop_front();
					req_ch.valid          <= 1'b1;
					req_ch.req_type       <= cur_req.kind;
					req_ch.request_bytes  <= cur_req.nbytes;
					req_ch.null_pointer   <= cur_req.is_null;
					req_ch.payload_offset <= cur_req.ptr;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// response monitor
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_q.size() == 0) begin
					flag_mismatch("unexpected transaction, status", int'(rsp_ch.status), -1);
				end else begin
					heap_result_t want;
					want = expected_q.pop_front();
					if (rsp_ch.status !== want.status)
						flag_mismatch("status", int'(rsp_ch.status), int'(want.status));
					if (rsp_ch.alloc_offset !== want.offset)
						flag_mismatch("alloc_offset", int'(rsp_ch.alloc_offset),
							int'(want.offset));
					if (rsp_ch.leaked_bytes !== want.leak_bytes)
						flag_mismatch("leaked_bytes", int'(rsp_ch.leaked_bytes),
							int'(want.leak_bytes));
					if (rsp_ch.leaked_objects !== want.leak_count)
						flag_mismatch("leaked_objects", int'(rsp_ch.leaked_objects),
							int'(want.leak_count));
					n_checked++;
				end
			end
			rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long receiver hold-off so that the core backs up into the request side
	initial begin
		hold_off = 1'b0;
		wait (arst_n === 1'b1);
		while (n_sent < 150)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic post_request(heap_req_t r);
		while (pend_q.size() >= 2)
			@(negedge clk);
		pend_q.push_back(r);
	endtask

	function automatic heap_req_t make_req(logic [1:0] kind, int nbytes, bit is_null,
		int ptr);
		heap_req_t r;
		r.kind = kind;
		r.nbytes = 12'(nbytes);
		r.is_null = is_null;
		r.ptr = 13'(ptr);
		return r;
	endfunction

	function automatic int pick_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return $urandom_range(32);
		if (roll < 85)
			return $urandom_range(256, 33);
		if (roll < 95)
			return $urandom_range(1024, 257);
		return $urandom_range(4095, 1025);
	endfunction

	initial begin
		heap_req_t r;
		int n_gen;
		int alloc_pct;
		int roll;
		int sub;
		int p;

		alloc_pct = 50;

		wait (arst_n === 1'b1);
		@(negedge clk);

		// directed corners: empty heap, header-only chunk, exact fit, free errors
		post_request(make_req(ffha_pkg::REQ_LEAK, 4095, 1'b1, 8191));
		post_request(make_req(ffha_pkg::REQ_ALLOC, 0, 1'b1, 8191));
		post_request(make_req(ffha_pkg::REQ_ALLOC, 1, 1'b0, 0));
		post_request(make_req(ffha_pkg::REQ_ALLOC, 4000, 1'b0, 0));
		post_request(make_req(ffha_pkg::REQ_ALLOC, 4095, 1'b0, 0));
		post_request(make_req(ffha_pkg::REQ_ALLOC, 100, 1'b0, 0));
		post_request(make_req(ffha_pkg::REQ_ALLOC, 48, 1'b0, 0));
		post_request(make_req(ffha_pkg::REQ_LEAK, 0, 1'b0, 0));
		post_request(make_req(ffha_pkg::REQ_FREE, 4095, 1'b1, 8191));
		post_request(make_req(ffha_pkg::REQ_FREE, 0, 1'b0, 4096));
		post_request(make_req(ffha_pkg::REQ_FREE, 0, 1'b0, 8191));
		post_request(make_req(ffha_pkg::REQ_FREE, 0, 1'b0, 8));
		post_request(make_req(ffha_pkg::REQ_FREE, 0, 1'b0, 8));
		post_request(make_req(ffha_pkg::REQ_FREE, 0, 1'b0, 0));
		post_request(make_req(ffha_pkg::REQ_FREE, 0, 1'b0, 17));
		post_request(make_req(ffha_pkg::REQ_FREE, 0, 1'b0, 16));
		post_request(make_req(ffha_pkg::REQ_FREE, 0, 1'b0, 32));
		post_request(make_req(ffha_pkg::REQ_FREE, 0, 1'b0, 4040));
		post_request(make_req(ffha_pkg::REQ_LEAK, 0, 1'b0, 0));
		post_request(make_req(REQ_UNKNOWN, 4095, 1'b1, 8191));
		post_request(make_req(ffha_pkg::REQ_ALLOC, 4088, 1'b0, 0));
		post_request(make_req(ffha_pkg::REQ_LEAK, 0, 1'b0, 0));
		post_request(make_req(ffha_pkg::REQ_FREE, 0, 1'b0, 8));

		n_gen = 0;
		while (n_gen < RANDOM_ITEMS) begin
			// stall profile by quarter of the random run
			case (n_gen * 4 / RANDOM_ITEMS)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			// shift the alloc/free balance so the heap both fills and drains
			if (n_gen % 100 == 0) begin
				case ($urandom_range(2))
					0: alloc_pct = 30;
					1: alloc_pct = 50;
					default: alloc_pct = 75;
				endcase
			end

			r.kind = ffha_pkg::REQ_FREE;
			r.nbytes = 12'($urandom_range(4095));
			r.is_null = 1'($urandom_range(1));
			r.ptr = 13'($urandom_range(8191));
			roll = $urandom_range(99);
			if (roll < 5) begin
				r.kind = REQ_UNKNOWN;
			end else if (roll < 15) begin
				r.kind = ffha_pkg::REQ_LEAK;
			end else if (roll < 15 + alloc_pct * 85 / 100) begin
				r.kind = ffha_pkg::REQ_ALLOC;
				r.nbytes = 12'(pick_size());
			end else begin
				r.is_null = 1'b0;
				sub = $urandom_range(99);
				if (sub < 70) begin
					p = pick_chunk(1'b1);
					if (p >= 0)
						r.ptr = 13'(p);
					else
						r.is_null = 1'b1;
				end else if (sub < 78) begin
					p = pick_chunk(1'b0);
					if (p >= 0)
						r.ptr = 13'(p);
				end else if (sub < 86) begin
					r.ptr = 13'($urandom_range(ffha_pkg::HEAP_BYTES - 1));
				end else if (sub < 93) begin
					r.is_null = 1'b1;
				end else begin
					r.ptr = 13'($urandom_range(8191, ffha_pkg::HEAP_BYTES));
				end
			end
			post_request(r);
			if (r.kind != REQ_UNKNOWN)
				n_gen++;
		end

		while (pend_q.size() > 0 || req_ch.valid || expected_q.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d requests: %0d ok, %0d out of memory, %0d leak reports",
			n_sent, status_cnt[int'(ffha_pkg::ST_OK)], status_cnt[int'(ffha_pkg::ST_NO_MEM)],
			n_leak_reports);
		$display("free errors: %0d out of bounds, %0d double, %0d inside; peak %0d live",
			status_cnt[int'(ffha_pkg::ST_OOB)], status_cnt[int'(ffha_pkg::ST_DBL_FREE)],
			status_cnt[int'(ffha_pkg::ST_INSIDE)], peak_live);
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches over %0d checked transactions", n_errors, n_checked);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ffha_pkg.sv
rtl/ffha_req_if.sv
rtl/ffha_rsp_if.sv
rtl/ffha_hdr_store.sv
rtl/first_fit_heap_allocator_core.sv
dv/tb_top.sv
